// ----- rtl/psc_pkg.sv -----
// Shared types and constants for the polynomial sign-change bracket core.
// Used by the configuration block, the evaluation lanes and the top level.
`default_nettype none

package psc_pkg;

  // Field widths.
  localparam int unsigned CoefW   = 16;
  localparam int unsigned GridW   = 8;
  localparam int unsigned PointW  = 9;
  localparam int unsigned ValueW  = 56;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DegreeW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegDegree = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefP0 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefP1 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefP2 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoefP3 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCoefP4 = 3'd5;

  // Coefficients after masking by the configured degree.
  typedef struct packed {
    logic signed [CoefW-1:0] c0;
    logic signed [CoefW-1:0] c1;
    logic signed [CoefW-1:0] c2;
    logic signed [CoefW-1:0] c3;
    logic signed [CoefW-1:0] c4;
  } psc_coef_t;

endpackage : psc_pkg

`default_nettype wire

// ----- rtl/psc_cfg.sv -----
// Configuration register file: degree and the five Q8.8 coefficients.
// Depends on psc_pkg; presents coefficients already masked by the degree.
`default_nettype none

module psc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [psc_pkg::CoefW-1:0]     cfg_wdata_i,
  output psc_pkg::psc_coef_t            coef_o
);
  import psc_pkg::*;

  logic [DegreeW-1:0]      degree_q;
  logic signed [CoefW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q;

  // Register writes; indexes without a register are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
      p0_q     <= '0;
      p1_q     <= '0;
      p2_q     <= '0;
      p3_q     <= '0;
      p4_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDegree: degree_q <= cfg_wdata_i[DegreeW-1:0];
        RegCoefP0: p0_q     <= cfg_wdata_i;
        RegCoefP1: p1_q     <= cfg_wdata_i;
        RegCoefP2: p2_q     <= cfg_wdata_i;
        RegCoefP3: p3_q     <= cfg_wdata_i;
        RegCoefP4: p4_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A power contributes only up to the degree; degrees above four keep all five.
  always_comb begin
    coef_o.c0 = p0_q;
    coef_o.c1 = (degree_q >= DegreeW'(1)) ? p1_q : '0;
    coef_o.c2 = (degree_q >= DegreeW'(2)) ? p2_q : '0;
    coef_o.c3 = (degree_q >= DegreeW'(3)) ? p3_q : '0;
    coef_o.c4 = (degree_q >= DegreeW'(4)) ? p4_q : '0;
  end

endmodule : psc_cfg

`default_nettype wire

// ----- rtl/psc_lane.sv -----
// Five-stage evaluation lane: powers of t, coefficient products and their sum.
// Depends on psc_pkg; one point enters per cycle, valid travels with the data.
`default_nettype none

module psc_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  psc_pkg::psc_coef_t                coef_i,
  input  logic                              valid_i,
  input  logic signed [psc_pkg::PointW-1:0] point_i,
  output logic                              valid_o,
  output logic signed [psc_pkg::ValueW-1:0] value_o
);
  import psc_pkg::*;

  // Valid bits of stages A to E.
  logic [4:0] vld_q;

  // Stage A: the point.
  logic signed [PointW-1:0] t_a_q;
  // Stage B: t, t squared, c1 * t.
  logic signed [PointW-1:0] t_b_q;
  logic signed [16:0]       t2_b_q;
  logic signed [24:0]       c1t_b_q;
  // Stage C: t cubed, t to the fourth, c2 * t^2, c0 + c1 * t.
  logic signed [25:0]       t3_c_q;
  logic signed [29:0]       t4_c_q;
  logic signed [32:0]       c2t2_c_q;
  logic signed [25:0]       s01_c_q;
  // Stage D: c3 * t^3, c4 * t^4, running sum of the lower terms.
  logic signed [41:0]       c3t3_d_q;
  logic signed [45:0]       c4t4_d_q;
  logic signed [33:0]       s012_d_q;
  // Stage E: the value.
  logic signed [ValueW-1:0] sum_e_q;

  logic signed [17:0] t2_full;
  logic signed [33:0] t4_full;

  assign t2_full = 18'(t_a_q) * 18'(t_a_q);
  assign t4_full = 34'(t2_b_q) * 34'(t2_b_q);

  // Valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Stage A.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      t_a_q <= point_i;
    end
  end

  // Stage B.
  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      t_b_q   <= t_a_q;
      t2_b_q  <= t2_full[16:0];
      c1t_b_q <= 25'(coef_i.c1) * 25'(t_a_q);
    end
  end

  // Stage C.
  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      t3_c_q   <= 26'(t2_b_q) * 26'(t_b_q);
      t4_c_q   <= t4_full[29:0];
      c2t2_c_q <= 33'(coef_i.c2) * 33'(t2_b_q);
      s01_c_q  <= 26'(coef_i.c0) + 26'(c1t_b_q);
    end
  end

  // Stage D.
  always_ff @(posedge clk_i) begin
    if (vld_q[2]) begin
      c3t3_d_q <= 42'(coef_i.c3) * 42'(t3_c_q);
      c4t4_d_q <= 46'(coef_i.c4) * 46'(t4_c_q);
      s012_d_q <= 34'(s01_c_q) + 34'(c2t2_c_q);
    end
  end

  // Stage E: final three-term add.
  always_ff @(posedge clk_i) begin
    if (vld_q[3]) begin
      sum_e_q <= ValueW'(s012_d_q) + ValueW'(c3t3_d_q) + ValueW'(c4t4_d_q);
    end
  end

  assign valid_o = vld_q[4];
  assign value_o = sum_e_q;

endmodule : psc_lane

`default_nettype wire

// ----- rtl/polynomial_sign_change_bracket_core.sv -----
// Polynomial sign-change bracket core: evaluates p(x) and p(x+1), flags opposite signs.
// Result: done_o is registered; each accepted point passes lane stages A to E, then the output stage.
// Throughput: one grid point per cycle; busy_o is tied low, since the five-stage lanes never stall.
// Reset: asynchronous, active low; clears the configuration registers, all valid bits and done_o, not the data.
// Depends on psc_pkg, psc_cfg and psc_lane.
`default_nettype none

module polynomial_sign_change_bracket_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [psc_pkg::GridW-1:0]  grid_x_i,
  input  logic                              cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [psc_pkg::CoefW-1:0]         cfg_wdata_i,
  output logic                              done_o,
  output logic signed [psc_pkg::ValueW-1:0] value_low_o,
  output logic signed [psc_pkg::ValueW-1:0] value_high_o,
  output logic                              bracket_found_o
);
  import psc_pkg::*;

  psc_coef_t                coef;
  logic                     accept;
  logic signed [PointW-1:0] point_lo, point_hi;
  logic                     valid_lo, valid_hi;
  logic signed [ValueW-1:0] value_lo, value_hi;
  logic                     bracket;
  logic                     done_q;
  logic signed [ValueW-1:0] value_low_q, value_high_q;
  logic                     bracket_q;

  // The pipeline takes a point every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Both ends of the unit interval; x + 1 reaches 128 at the top grid point.
  assign point_lo = PointW'(grid_x_i);
  assign point_hi = point_lo + PointW'(1);

  psc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .coef_o     (coef)
  );

  psc_lane u_lane_lo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef),
    .valid_i(accept),
    .point_i(point_lo),
    .valid_o(valid_lo),
    .value_o(value_lo)
  );

  psc_lane u_lane_hi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef),
    .valid_i(accept),
    .point_i(point_hi),
    .valid_o(valid_hi),
    .value_o(value_hi)
  );

  // Opposite signs with neither value zero.
  assign bracket = (value_lo[ValueW-1] ^ value_hi[ValueW-1])
                   && (value_lo != '0) && (value_hi != '0);

  // Output stage: result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_lo;
    end
  end

  // Output stage: result payload.
  always_ff @(posedge clk_i) begin
    if (valid_lo) begin
      value_low_q  <= value_lo;
      value_high_q <= value_hi;
      bracket_q    <= bracket;
    end
  end

  assign done_o          = done_q;
  assign value_low_o     = value_low_q;
  assign value_high_o    = value_high_q;
  assign bracket_found_o = bracket_q;

  // The two lanes advance in lockstep.
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_lo == valid_hi)
    else $error("evaluation lanes lost alignment");

  // Every accepted point is followed by its result strobe on done_o.
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("result strobe missing after accepted point");

  // A flagged bracket never comes with a zero value at either end.
  a_bracket_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bracket_found_o) |-> (value_low_o != '0 && value_high_o != '0))
    else $error("bracket flagged with a zero endpoint");

endmodule : polynomial_sign_change_bracket_core

`default_nettype wire

// ----- tb/sv/polynomial_sign_change_bracket_core_tb.sv -----
// Testbench for the polynomial sign-change bracket core: directed and random grid scans,
// each result checked against a local polynomial evaluator. Depends on psc_pkg and the core.
`timescale 1ns / 100ps

module polynomial_sign_change_bracket_core_tb;
  import psc_pkg::*;

  localparam int MaxDegree   = 4;
  localparam int PipeLatency = 6;
  localparam int PhaseCount  = 6;
  localparam int PhasePoints = 150;
  localparam int TimeoutNs   = 2_000_000;
  localparam int MaxPrinted  = 40;

  // Indexes that have no register behind them.
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  // One predicted result of the core.
  typedef struct {
    logic signed [GridW-1:0]  grid_x;
    logic signed [ValueW-1:0] value_low;
    logic signed [ValueW-1:0] value_high;
    logic                     bracket_found;
  } bracket_eval_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic signed [GridW-1:0]    grid_x_i;
  logic                       cfg_we_i;
  logic [CfgIdxW-1:0]         cfg_idx_i;
  logic [CoefW-1:0]           cfg_wdata_i;
  logic                       done_o;
  logic signed [ValueW-1:0]   value_low_o;
  logic signed [ValueW-1:0]   value_high_o;
  logic                       bracket_found_o;

  // Local copy of the configuration registers.
  logic [DegreeW-1:0]         model_degree;
  logic signed [CoefW-1:0]    model_coef [5];

  bracket_eval_t              predicted_evals [$];
  int                         error_count;
  int                         results_checked;
  int                         brackets_seen;
  int                         settings_applied;

  polynomial_sign_change_bracket_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .grid_x_i       (grid_x_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .value_low_o    (value_low_o),
    .value_high_o   (value_high_o),
    .bracket_found_o(bracket_found_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the core hangs.
  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d results still outstanding.", predicted_evals.size());
    $display("== FAIL ==");
    $finish;
  end

  // Evaluate the configured polynomial exactly at integer point t.
  function automatic longint poly_at(input longint t);
    longint sum;
    longint pw;
    int     top;
    top = (model_degree > MaxDegree) ? MaxDegree : int'(model_degree);
    sum = 0;
    pw  = 1;
    for (int k = 0; k <= top; k++) begin
      sum += longint'(model_coef[k]) * pw;
      if (k < top) pw *= t;
    end
    return sum;
  endfunction

  // Predict the result for one grid point under the current registers.
  function automatic bracket_eval_t predict_bracket(input logic signed [GridW-1:0] x);
    bracket_eval_t r;
    longint        lo;
    longint        hi;
    lo = poly_at(longint'(x));
    hi = poly_at(longint'(x) + 1);
    r.grid_x        = x;
    r.value_low     = lo[ValueW-1:0];
    r.value_high    = hi[ValueW-1:0];
    r.bracket_found = ((lo < 0) && (hi > 0)) || ((lo > 0) && (hi < 0));
    return r;
  endfunction

  // Count one mismatch; print a line for it only among the first MaxPrinted.
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Record accepted points and check every result strobe against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    bracket_eval_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (predicted_evals.size() == 0) begin
          report_mismatch("result strobe with no grid point outstanding");
        end else begin
          want = predicted_evals.pop_front();
          results_checked++;
          if (want.bracket_found) brackets_seen++;
          if (value_low_o !== want.value_low)
            report_mismatch($sformatf("x=%0d value_low got %0d want %0d",
                                      want.grid_x, value_low_o, want.value_low));
          if (value_high_o !== want.value_high)
            report_mismatch($sformatf("x=%0d value_high got %0d want %0d",
                                      want.grid_x, value_high_o, want.value_high));
          if (bracket_found_o !== want.bracket_found)
            report_mismatch($sformatf("x=%0d bracket_found got %b want %b",
                                      want.grid_x, bracket_found_o, want.bracket_found));
        end
      end
      if (start_i && !busy_o) predicted_evals.push_back(predict_bracket(grid_x_i));
    end
  end

  // Offer one grid point and hold it until the core takes the transfer.
  // Called and returns at a falling edge; start stays high for a following point.
  task automatic send_point(input logic signed [GridW-1:0] x);
    logic taken;
    start_i  <= 1'b1;
    grid_x_i <= x;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
      @(negedge clk_i);
    end
  endtask

  task automatic idle_cycles(input int n);
    start_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Random gaps on the sender side; pct is the share of cycles left idle.
  task automatic pace(input int pct);
    while (pct > 0 && $urandom_range(0, 99) < pct) idle_cycles(1);
  endtask

  // Stop sending and let the pipeline empty before touching registers.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (predicted_evals.size() != 0) @(negedge clk_i);
    repeat (PipeLatency + 2) @(negedge clk_i);
  endtask

  // One register write; the enable is left high so back-to-back writes stay clean.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    case (idx)
      RegDegree: model_degree  = data[DegreeW-1:0];
      RegCoefP0: model_coef[0] = data;
      RegCoefP1: model_coef[1] = data;
      RegCoefP2: model_coef[2] = data;
      RegCoefP3: model_coef[3] = data;
      RegCoefP4: model_coef[4] = data;
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    cfg_we_i <= 1'b0;
    repeat (2) @(negedge clk_i);
  endtask

  // Load a whole polynomial once the core is idle.
  task automatic program_poly(input logic [DegreeW-1:0] deg,
                              input logic [CoefW-1:0] c0, input logic [CoefW-1:0] c1,
                              input logic [CoefW-1:0] c2, input logic [CoefW-1:0] c3,
                              input logic [CoefW-1:0] c4);
    wait_idle();
    write_reg(RegDegree, CoefW'(deg));
    write_reg(RegCoefP0, c0);
    write_reg(RegCoefP1, c1);
    write_reg(RegCoefP2, c2);
    write_reg(RegCoefP3, c3);
    write_reg(RegCoefP4, c4);
    end_cfg();
    settings_applied++;
  endtask

  // Mix of full-range, small, extreme and whole-number coefficients.
  function automatic logic [CoefW-1:0] rand_coef();
    int mode;
    mode = $urandom_range(0, 3);
    case (mode)
      0: return CoefW'($urandom_range(0, 65535));
      1: return CoefW'(int'($urandom_range(0, 1200)) - 600);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return CoefW'((int'($urandom_range(0, 16)) - 8) * 256);
    endcase
  endfunction

  // Registers at their reset values: everything evaluates to zero.
  task automatic test_reset_state();
    send_point(8'sd0);
    send_point(-8'sd128);
    send_point(8'sd127);
  endtask

  // Largest magnitudes at both ends of the grid, including the top point.
  task automatic test_coef_extremes();
    program_poly(3'd4, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_point(-8'sd128);
    send_point(8'sd127);
    send_point(-8'sd1);
    program_poly(3'd4, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(-8'sd128);
    send_point(8'sd127);
    send_point(8'sd126);
  endtask

  // Degrees above the maximum behave like the maximum.
  task automatic test_degree_saturation();
    program_poly(3'd5, 16'h0123, 16'hFE00, 16'h0080, 16'hFFC0, 16'h0011);
    send_point(8'sd3);
    wait_idle();
    write_reg(RegDegree, 16'd6);
    end_cfg();
    send_point(-8'sd7);
    wait_idle();
    write_reg(RegDegree, 16'd7);
    end_cfg();
    send_point(8'sd100);
  endtask

  // Sign changes in both directions, and a zero at either end giving no bracket.
  task automatic test_zero_and_bracket();
    program_poly(3'd1, 16'hFF00, 16'h0200, 16'h0000, 16'h0000, 16'h0000);
    send_point(8'sd0);
    send_point(-8'sd1);
    program_poly(3'd1, 16'h0100, 16'hFE00, 16'h0000, 16'h0000, 16'h0000);
    send_point(8'sd0);
    program_poly(3'd1, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
    send_point(8'sd0);
    send_point(-8'sd1);
  endtask

  // Writes to indexes without a register must leave the polynomial untouched.
  task automatic test_unknown_index();
    wait_idle();
    write_reg(RegUnusedLo, 16'hFFFF);
    write_reg(RegUnusedHi, 16'h8000);
    end_cfg();
    send_point(8'sd5);
    send_point(-8'sd5);
  endtask

  // Random and extreme polynomials; mostly ascending scans with some stray points in between.
  task automatic test_random_scans();
    int               idle_pct;
    int               sent;
    int               scan_start;
    int               scan_len;
    logic [DegreeW-1:0] deg;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: deg = 3'd4;
        1: deg = 3'd0;
        2: deg = 3'd7;
        default: deg = DegreeW'($urandom_range(0, 7));
      endcase
      if (phase == 3)
        program_poly(deg, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      else
        program_poly(deg, rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 86;
        default: idle_pct = 32;
      endcase
      sent = 0;
      while (sent < PhasePoints) begin
        if ($urandom_range(0, 99) < 20) begin
          send_point(GridW'($urandom_range(0, 255)));
          pace(idle_pct);
          sent++;
        end else begin
          if ($urandom_range(0, 99) < 60) scan_start = int'($urandom_range(0, 40)) - 20;
          else scan_start = int'($urandom_range(0, 255)) - 128;
          scan_len = $urandom_range(2, 24);
          for (int i = 0; i < scan_len && scan_start + i <= 127; i++) begin
            send_point(GridW'(scan_start + i));
            pace(idle_pct);
            sent++;
          end
        end
      end
    end
  endtask

  // Main sequence.
  initial begin
    int guard;
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    grid_x_i         = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = RegDegree;
    cfg_wdata_i      = '0;
    model_degree     = '0;
    for (int k = 0; k < 5; k++) model_coef[k] = '0;
    error_count      = 0;
    results_checked  = 0;
    brackets_seen    = 0;
    settings_applied = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_state();
    test_coef_extremes();
    test_degree_saturation();
    test_zero_and_bracket();
    test_unknown_index();
    test_random_scans();

    // Drain the pipeline, then watch a little longer for stray strobes.
    start_i <= 1'b0;
    guard = 0;
    while (predicted_evals.size() != 0 && guard < 1000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (PipeLatency + 4) @(negedge clk_i);
    if (predicted_evals.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_evals.size()));

    $display("Checked %0d results over %0d register settings and the reset state.",
             results_checked, settings_applied);
    $display("%0d of those results flagged a sign change; %0d mismatches.",
             brackets_seen, error_count);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/psc_pkg.sv
rtl/psc_cfg.sv
rtl/psc_lane.sv
rtl/polynomial_sign_change_bracket_core.sv
tb/sv/polynomial_sign_change_bracket_core_tb.sv
